// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: design/pse_pkg.sv
package pse_pkg;

    localparam int WORD_BITS    = 32;
    localparam int FRAC_BITS    = 24;
    localparam int PIPE_DEPTH   = 8;
    localparam int CFG_IDX_BITS = 3;

    typedef logic signed [WORD_BITS-1:0] t_word;

    localparam t_word W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic signed [2*WORD_BITS-1:0] MUL_RND =
        (2*WORD_BITS)'(1) <<< (FRAC_BITS-1);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_A_BASE = CFG_IDX_BITS'(0),
        REG_A_SLOPE = CFG_IDX_BITS'(1),
        REG_B_BASE = CFG_IDX_BITS'(2),
        REG_B_SLOPE = CFG_IDX_BITS'(3),
        REG_G_BASE = CFG_IDX_BITS'(4),
        REG_G_SLOPE = CFG_IDX_BITS'(5)
    } t_cfg_idx;

    typedef struct packed {
        t_word phi;
        t_word grad_x;
        t_word grad_y;
        t_word grad_z;
        t_word laplacian;
        t_word temperature;
    } t_in;

    typedef struct packed {
        t_word energy_density;
        t_word chem_potential;
        t_word stress_xx;
        t_word stress_yy;
        t_word stress_zz;
        t_word stress_xy;
        t_word stress_xz;
        t_word stress_yz;
        logic  overflow;
    } t_out;

    typedef struct packed {
        t_word a_base;
        t_word a_slope;
        t_word b_base;
        t_word b_slope;
        t_word gradient_base;
        t_word gradient_slope;
    } t_coef;

    typedef struct packed {
        t_word v;
        logic  s;
    } t_res;

    function automatic t_res f_mul(input t_word a, input t_word b);
        logic signed [2*WORD_BITS-1:0] p;
        logic signed [2*WORD_BITS-1:0] q;
        t_res r;
        p = (2*WORD_BITS)'(a) * (2*WORD_BITS)'(b);
        q = (p + MUL_RND) >>> FRAC_BITS;
        r.s = !((&q[2*WORD_BITS-1:WORD_BITS-1]) || !(|q[2*WORD_BITS-1:WORD_BITS-1]));
        r.v = r.s ? (q[2*WORD_BITS-1] ? W_MIN : W_MAX) : q[WORD_BITS-1:0];
        return r;
    endfunction

    function automatic t_res f_add(input t_word a, input t_word b);
        logic signed [WORD_BITS:0] s;
        t_res r;
        s = (WORD_BITS+1)'(a) + (WORD_BITS+1)'(b);
        r.s = s[WORD_BITS] ^ s[WORD_BITS-1];
        r.v = r.s ? (s[WORD_BITS] ? W_MIN : W_MAX) : s[WORD_BITS-1:0];
        return r;
    endfunction

    function automatic t_res f_sub(input t_word a, input t_word b);
        logic signed [WORD_BITS:0] s;
        t_res r;
        s = (WORD_BITS+1)'(a) - (WORD_BITS+1)'(b);
        r.s = s[WORD_BITS] ^ s[WORD_BITS-1];
        r.v = r.s ? (s[WORD_BITS] ? W_MIN : W_MAX) : s[WORD_BITS-1:0];
        return r;
    endfunction

    // x * 0.5 rounded half up
    function automatic t_word f_half(input t_word a);
        logic signed [WORD_BITS:0] s;
        s = (WORD_BITS+1)'(a) + (WORD_BITS+1)'(1);
        return s[WORD_BITS:1];
    endfunction

    // x * 0.25 rounded half up
    function automatic t_word f_quarter(input t_word a);
        logic signed [WORD_BITS+1:0] s;
        s = (WORD_BITS+2)'(a) + (WORD_BITS+2)'(2);
        return s[WORD_BITS+1:2];
    endfunction

    // x * 0.75 rounded half up
    function automatic t_word f_threeq(input t_word a);
        logic signed [WORD_BITS+1:0] s;
        s = (WORD_BITS+2)'(a) + ((WORD_BITS+2)'(a) <<< 1) + (WORD_BITS+2)'(2);
        return s[WORD_BITS+1:2];
    endfunction

endpackage

// File: design/pse_cfg.sv
module pse_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [pse_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  pse_pkg::t_word                      i_cfg_data,
    output logic                                o_cfg_ready,
    output pse_pkg::t_coef                      o_coef
);
    import pse_pkg::*;

    t_coef r_coef;
    t_coef n_coef;

    assign o_cfg_ready = 1'b1;
    assign o_coef      = r_coef;

    always_comb begin
        n_coef = r_coef;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_A_BASE:  n_coef.a_base         = i_cfg_data;
                REG_A_SLOPE: n_coef.a_slope        = i_cfg_data;
                REG_B_BASE:  n_coef.b_base         = i_cfg_data;
                REG_B_SLOPE: n_coef.b_slope        = i_cfg_data;
                REG_G_BASE:  n_coef.gradient_base  = i_cfg_data;
                REG_G_SLOPE: n_coef.gradient_slope = i_cfg_data;
                default:     n_coef                = r_coef;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else begin
            r_coef <= n_coef;
        end
    end

endmodule

// File: design/phi4_site_energy_stress.sv
// An accepted input word passes through stage registers r_s1..r_s7 and r_out to o_out.
// Throughput: one word per cycle while i_out_stall is low; 8 stages of multiplies and adds.
// A stalled output only blocks upstream stages that hold valid words (bubbles collapse).
// Reset (synchronous, active low) clears the stage valid bits and the coefficient
// registers; pipeline data is not reset.
`include "assert_macros.svh"

module phi4_site_energy_stress (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  pse_pkg::t_in                        i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output pse_pkg::t_out                       o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pse_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  pse_pkg::t_word                      i_cfg_data
);
    import pse_pkg::*;

    typedef struct packed {
        t_word kxx;
        t_word kyy;
        t_word kzz;
        t_word kxy;
        t_word kxz;
        t_word kyz;
    } t_kg;

    typedef struct packed {
        t_word m_a, m_b, m_k, p2;
        t_word gxx, gyy, gzz, gxy, gxz, gyz;
        t_word plap, phi, lap;
        logic  sat;
    } t_s1;

    typedef struct packed {
        t_word a, b, k, g2a, p4, p3, p2;
        t_word gxx, gyy, gzz, gxy, gxz, gyz;
        t_word plap, phi, lap;
        logic  sat;
    } t_s2;

    typedef struct packed {
        t_word g2, ha_c, qb, tb, hk_c;
        t_word aphi, bp3, kl, kpl, p2, p4;
        t_kg   kg;
        logic  sat;
    } t_s3;

    typedef struct packed {
        t_word ha, hk, qe, te, mu1, kl, kpl;
        t_kg   kg;
        logic  sat;
    } t_s4;

    typedef struct packed {
        t_word fed1, p01, mu, hk, kpl;
        t_kg   kg;
        logic  sat;
    } t_s5;

    typedef struct packed {
        t_word fed, p02, hk, mu;
        t_kg   kg;
        logic  sat;
    } t_s6;

    typedef struct packed {
        t_word p0, fed, mu;
        t_kg   kg;
        logic  sat;
    } t_s7;

    t_coef cf;
    logic [PIPE_DEPTH:0]   adv;
    logic [PIPE_DEPTH-1:0] r_vld;

    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    t_s3  r_s3, n_s3;
    t_s4  r_s4, n_s4;
    t_s5  r_s5, n_s5;
    t_s6  r_s6, n_s6;
    t_s7  r_s7, n_s7;
    t_out r_out, n_out;

    pse_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_coef      (cf)
    );

    // advance a stage when it is empty or the stage after it advances
    always_comb begin
        adv[PIPE_DEPTH] = !i_out_stall;
        for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_in_stall  = !adv[0];
    assign o_out_valid = r_vld[PIPE_DEPTH-1];
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin : s1_calc
        t_res ma, mb, mk, sq, xx, yy, zz, xy, xz, yz, pl;
        ma = f_mul(cf.a_slope, i_in.temperature);
        mb = f_mul(cf.b_slope, i_in.temperature);
        mk = f_mul(cf.gradient_slope, i_in.temperature);
        sq = f_mul(i_in.phi, i_in.phi);
        xx = f_mul(i_in.grad_x, i_in.grad_x);
        yy = f_mul(i_in.grad_y, i_in.grad_y);
        zz = f_mul(i_in.grad_z, i_in.grad_z);
        xy = f_mul(i_in.grad_x, i_in.grad_y);
        xz = f_mul(i_in.grad_x, i_in.grad_z);
        yz = f_mul(i_in.grad_y, i_in.grad_z);
        pl = f_mul(i_in.phi, i_in.laplacian);
        n_s1.m_a  = ma.v;
        n_s1.m_b  = mb.v;
        n_s1.m_k  = mk.v;
        n_s1.p2   = sq.v;
        n_s1.gxx  = xx.v;
        n_s1.gyy  = yy.v;
        n_s1.gzz  = zz.v;
        n_s1.gxy  = xy.v;
        n_s1.gxz  = xz.v;
        n_s1.gyz  = yz.v;
        n_s1.plap = pl.v;
        n_s1.phi  = i_in.phi;
        n_s1.lap  = i_in.laplacian;
        n_s1.sat  = ma.s | mb.s | mk.s | sq.s | xx.s | yy.s | zz.s
                  | xy.s | xz.s | yz.s | pl.s;
    end

    always_comb begin : s2_calc
        t_res ca, cb, ck, ga, q4, q3;
        ca = f_add(cf.a_base, r_s1.m_a);
        cb = f_add(cf.b_base, r_s1.m_b);
        ck = f_add(cf.gradient_base, r_s1.m_k);
        ga = f_add(r_s1.gxx, r_s1.gyy);
        q4 = f_mul(r_s1.p2, r_s1.p2);
        q3 = f_mul(r_s1.p2, r_s1.phi);
        n_s2.a    = ca.v;
        n_s2.b    = cb.v;
        n_s2.k    = ck.v;
        n_s2.g2a  = ga.v;
        n_s2.p4   = q4.v;
        n_s2.p3   = q3.v;
        n_s2.p2   = r_s1.p2;
        n_s2.gxx  = r_s1.gxx;
        n_s2.gyy  = r_s1.gyy;
        n_s2.gzz  = r_s1.gzz;
        n_s2.gxy  = r_s1.gxy;
        n_s2.gxz  = r_s1.gxz;
        n_s2.gyz  = r_s1.gyz;
        n_s2.plap = r_s1.plap;
        n_s2.phi  = r_s1.phi;
        n_s2.lap  = r_s1.lap;
        n_s2.sat  = r_s1.sat | ca.s | cb.s | ck.s | ga.s | q4.s | q3.s;
    end

    always_comb begin : s3_calc
        t_res g2, ap, bp, kl, kp, xx, yy, zz, xy, xz, yz;
        g2 = f_add(r_s2.g2a, r_s2.gzz);
        ap = f_mul(r_s2.a, r_s2.phi);
        bp = f_mul(r_s2.b, r_s2.p3);
        kl = f_mul(r_s2.k, r_s2.lap);
        kp = f_mul(r_s2.k, r_s2.plap);
        xx = f_mul(r_s2.k, r_s2.gxx);
        yy = f_mul(r_s2.k, r_s2.gyy);
        zz = f_mul(r_s2.k, r_s2.gzz);
        xy = f_mul(r_s2.k, r_s2.gxy);
        xz = f_mul(r_s2.k, r_s2.gxz);
        yz = f_mul(r_s2.k, r_s2.gyz);
        n_s3.g2     = g2.v;
        n_s3.ha_c   = f_half(r_s2.a);
        n_s3.qb     = f_quarter(r_s2.b);
        n_s3.tb     = f_threeq(r_s2.b);
        n_s3.hk_c   = f_half(r_s2.k);
        n_s3.aphi   = ap.v;
        n_s3.bp3    = bp.v;
        n_s3.kl     = kl.v;
        n_s3.kpl    = kp.v;
        n_s3.p2     = r_s2.p2;
        n_s3.p4     = r_s2.p4;
        n_s3.kg.kxx = xx.v;
        n_s3.kg.kyy = yy.v;
        n_s3.kg.kzz = zz.v;
        n_s3.kg.kxy = xy.v;
        n_s3.kg.kxz = xz.v;
        n_s3.kg.kyz = yz.v;
        n_s3.sat    = r_s2.sat | g2.s | ap.s | bp.s | kl.s | kp.s
                    | xx.s | yy.s | zz.s | xy.s | xz.s | yz.s;
    end

    always_comb begin : s4_calc
        t_res ha, hk, qe, te, mu;
        ha = f_mul(r_s3.ha_c, r_s3.p2);
        hk = f_mul(r_s3.hk_c, r_s3.g2);
        qe = f_mul(r_s3.qb, r_s3.p4);
        te = f_mul(r_s3.tb, r_s3.p4);
        mu = f_add(r_s3.aphi, r_s3.bp3);
        n_s4.ha  = ha.v;
        n_s4.hk  = hk.v;
        n_s4.qe  = qe.v;
        n_s4.te  = te.v;
        n_s4.mu1 = mu.v;
        n_s4.kl  = r_s3.kl;
        n_s4.kpl = r_s3.kpl;
        n_s4.kg  = r_s3.kg;
        n_s4.sat = r_s3.sat | ha.s | hk.s | qe.s | te.s | mu.s;
    end

    always_comb begin : s5_calc
        t_res fe, pa, mu;
        fe = f_add(r_s4.ha, r_s4.qe);
        pa = f_add(r_s4.ha, r_s4.te);
        mu = f_sub(r_s4.mu1, r_s4.kl);
        n_s5.fed1 = fe.v;
        n_s5.p01  = pa.v;
        n_s5.mu   = mu.v;
        n_s5.hk   = r_s4.hk;
        n_s5.kpl  = r_s4.kpl;
        n_s5.kg   = r_s4.kg;
        n_s5.sat  = r_s4.sat | fe.s | pa.s | mu.s;
    end

    always_comb begin : s6_calc
        t_res fe, pb;
        fe = f_add(r_s5.fed1, r_s5.hk);
        pb = f_sub(r_s5.p01, r_s5.kpl);
        n_s6.fed = fe.v;
        n_s6.p02 = pb.v;
        n_s6.hk  = r_s5.hk;
        n_s6.mu  = r_s5.mu;
        n_s6.kg  = r_s5.kg;
        n_s6.sat = r_s5.sat | fe.s | pb.s;
    end

    always_comb begin : s7_calc
        t_res pc;
        pc = f_sub(r_s6.p02, r_s6.hk);
        n_s7.p0  = pc.v;
        n_s7.fed = r_s6.fed;
        n_s7.mu  = r_s6.mu;
        n_s7.kg  = r_s6.kg;
        n_s7.sat = r_s6.sat | pc.s;
    end

    always_comb begin : s8_calc
        t_res dx, dy, dz;
        dx = f_add(r_s7.p0, r_s7.kg.kxx);
        dy = f_add(r_s7.p0, r_s7.kg.kyy);
        dz = f_add(r_s7.p0, r_s7.kg.kzz);
        n_out.energy_density = r_s7.fed;
        n_out.chem_potential = r_s7.mu;
        n_out.stress_xx      = dx.v;
        n_out.stress_yy      = dy.v;
        n_out.stress_zz      = dz.v;
        n_out.stress_xy      = r_s7.kg.kxy;
        n_out.stress_xz      = r_s7.kg.kxz;
        n_out.stress_yz      = r_s7.kg.kyz;
        n_out.overflow       = r_s7.sat | dx.s | dy.s | dz.s;
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_s1 <= n_s1;
        end
        if (adv[1]) begin
            r_s2 <= n_s2;
        end
        if (adv[2]) begin
            r_s3 <= n_s3;
        end
        if (adv[3]) begin
            r_s4 <= n_s4;
        end
        if (adv[4]) begin
            r_s5 <= n_s5;
        end
        if (adv[5]) begin
            r_s6 <= n_s6;
        end
        if (adv[6]) begin
            r_s7 <= n_s7;
        end
        if (adv[7]) begin
            r_out <= n_out;
        end
    end

    `ASSERT_IMPLIES(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall, &r_vld)
    `ASSERT_IMPLIES(a_free_out_frees_in, i_clk, i_rst_n, !i_out_stall, !o_in_stall)
    `ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_vld[0])

endmodule
